### hw/rtl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Types and constants shared by the premultiplied bilinear sampler.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic WRAP_RING      = 1'b0;
    localparam logic WRAP_SPHERICAL = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam int WIDTH_RESET  = 256;
    localparam int HEIGHT_RESET = 128;

    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [15:0] HALF_Q16   = 16'd32768;
    localparam logic [16:0] FULL_Q15   = 17'd32768;
    localparam logic [15:0] NORM_DIV   = 16'd65025;
    localparam logic [16:0] NORM_RECIP = 17'd66051;
    localparam logic [31:0] NORM_BIAS  = 32'd4261478400;
    localparam int          NORM_SHIFT = 17;
    localparam logic [15:0] ALPHA_FULL = 16'd255;

    localparam int ACC_W  = 48;
    localparam int SUM_W  = 49;
    localparam int T_W    = 31;
    localparam int WT_W   = 33;
    localparam int PM_W   = 16;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         texel_col;
        logic [6:0]         texel_row;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [7:0]         alpha_in;
        logic signed [23:0] u_coord;
        logic signed [23:0] v_coord;
    } req_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
    } rsp_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } texel_t;

    typedef struct packed {
        logic        vld;
        logic [15:0] fx;
        logic [15:0] fy;
    } frac_t;

endpackage

### hw/rtl/premultiplied_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// premultiplied_bilinear_sampler
// Bilinear texture sampler with premultiplied alpha over an RGBA8 store.
//
// Request channel (req_valid, req_stall, req): cmd CMD_WRITE stores one
// texel, cmd CMD_SAMPLE filters at signed Q8.16 coordinates (u, v).
// Response channel (rsp_valid, rsp_stall, rsp): one Q1.15 RGBA transaction
// per sample, none per write, in request order.
// Configuration (cfg_wen, cfg_index, cfg_data): write only while idle.
// Throughput: one transaction per cycle while req_stall is low, set by the
// two texel store copies, each read at two addresses per cycle. The request
// edge loads the scale multiply; the response then passes the store read,
// three blend stages, the sum stage, two divide stages and the output
// register.
// Reset clears all valids and loads the default mode and sizes; the store
// holds nothing defined until written and needs no clearing pass.
// A stalled response holds; the pipeline keeps advancing until a result
// reaches the last stage behind it, then req_stall rises.
// ----------------------------------------------------------------------------
module premultiplied_bilinear_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  pbs_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output pbs_pkg::rsp_t                       rsp,
    input  logic                                cfg_wen,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HH    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_HEIGHT * (2 ** CW);
    localparam int W_RST = (pbs_pkg::WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : pbs_pkg::WIDTH_RESET;
    localparam int H_RST = (pbs_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : pbs_pkg::HEIGHT_RESET;

    logic             wrap_mode_reg;
    logic [WW-1:0]    width_reg;
    logic [HH-1:0]    height_reg;
    logic [WW-1:0]    width_next;
    logic [HH-1:0]    height_next;
    logic [7:0]       height_raw;

    logic             adv;
    logic             we;
    logic [AW-1:0]    waddr;
    pbs_pkg::texel_t  wdata;
    logic [AW-1:0]    raddr [4];
    pbs_pkg::texel_t  rdata [4];
    pbs_pkg::frac_t   frac;
    logic             acc_vld;
    logic [pbs_pkg::T_W-1:0] acc [4];

    assign height_raw = cfg_data[7:0];

    always_comb
    begin
        if (cfg_data == '0)
        begin
            width_next = WW'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
        begin
            width_next = WW'(MAX_WIDTH);
        end
        else
        begin
            width_next = WW'(cfg_data);
        end

        if (height_raw == '0)
        begin
            height_next = HH'(1);
        end
        else if (32'(height_raw) > 32'(MAX_HEIGHT))
        begin
            height_next = HH'(MAX_HEIGHT);
        end
        else
        begin
            height_next = HH'(height_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg <= pbs_pkg::WRAP_SPHERICAL;
            width_reg     <= WW'(W_RST);
            height_reg    <= HH'(H_RST);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                pbs_pkg::REG_WRAP_MODE:    wrap_mode_reg <= cfg_data[0];
                pbs_pkg::REG_IMAGE_WIDTH:  width_reg     <= width_next;
                pbs_pkg::REG_IMAGE_HEIGHT: height_reg    <= height_next;
                default:                   wrap_mode_reg <= wrap_mode_reg;
            endcase
        end
    end

    assign req_stall = !adv;

    pbs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HH         (HH),
        .CW         (CW),
        .RW         (RW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .req_valid (req_valid),
        .req       (req),
        .wrap_mode (wrap_mode_reg),
        .width     (width_reg),
        .height    (height_reg),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .frac      (frac)
    );

    pbs_texel_mem #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .en    (adv),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pbs_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .frac    (frac),
        .rdata   (rdata),
        .acc_vld (acc_vld),
        .acc     (acc)
    );

    pbs_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_vld   (acc_vld),
        .acc       (acc),
        .rsp_stall (rsp_stall),
        .adv       (adv),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

### hw/rtl/pbs_texel_mem.sv
// ----------------------------------------------------------------------------
// pbs_texel_mem
// Texel store: two copies, one per texel row of the footprint, each with one
// write port and two registered read ports.
// ----------------------------------------------------------------------------
module pbs_texel_mem #(
    parameter int AW    = 15,
    parameter int DEPTH = 32768
) (
    input  logic                clk,
    input  logic                en,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  pbs_pkg::texel_t     wdata,
    input  logic [AW-1:0]       raddr [4],
    output pbs_pkg::texel_t     rdata [4]
);

    pbs_pkg::texel_t top_mem [DEPTH];
    pbs_pkg::texel_t bot_mem [DEPTH];
    pbs_pkg::texel_t rdata_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                top_mem[waddr] <= wdata;
                bot_mem[waddr] <= wdata;
            end
            rdata_reg[0] <= top_mem[raddr[0]];
            rdata_reg[1] <= top_mem[raddr[1]];
            rdata_reg[2] <= bot_mem[raddr[2]];
            rdata_reg[3] <= bot_mem[raddr[3]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pbs_front.sv
// ----------------------------------------------------------------------------
// pbs_front
// Coordinate front end: wrap or clamp, scale to texel space, then form the
// four footprint addresses and the write request.
// ----------------------------------------------------------------------------
module pbs_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128,
    parameter int WW         = 9,
    parameter int HH         = 8,
    parameter int CW         = 8,
    parameter int RW         = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 req_valid,
    input  pbs_pkg::req_t        req,
    input  logic                 wrap_mode,
    input  logic [WW-1:0]        width,
    input  logic [HH-1:0]        height,
    output logic                 we,
    output logic [RW+CW-1:0]     waddr,
    output pbs_pkg::texel_t      wdata,
    output logic [RW+CW-1:0]     raddr [4],
    output pbs_pkg::frac_t       frac
);

    localparam int PXW = 16 + WW;
    localparam int PYW = 16 + HH;

    logic              vld1_reg;
    logic              wr1_reg;
    logic              inrange1_reg;
    logic [RW+CW-1:0]  waddr1_reg;
    pbs_pkg::texel_t   wdata1_reg;
    logic [PXW-1:0]    px1_reg;
    logic [PYW-1:0]    py1_reg;

    logic [16:0]       uq;
    logic [16:0]       vq;
    logic [31:0]       col_ext;
    logic [31:0]       row_ext;
    logic              sph;
    logic [WW-1:0]     kx;
    logic [HH-1:0]     ky;
    logic [WW-1:0]     col0;
    logic [WW-1:0]     col1;
    logic [HH-1:0]     row0;
    logic [HH-1:0]     row1;

    assign sph = (wrap_mode == pbs_pkg::WRAP_SPHERICAL);

    always_comb
    begin
        if (sph)
        begin
            uq = {1'b0, req.u_coord[15:0]};
        end
        else if (req.u_coord[23])
        begin
            uq = '0;
        end
        else if (req.u_coord[22:0] > 23'(pbs_pkg::ONE_Q16))
        begin
            uq = pbs_pkg::ONE_Q16;
        end
        else
        begin
            uq = req.u_coord[16:0];
        end

        if (!sph)
        begin
            vq = {1'b0, req.v_coord[15:0]};
        end
        else if (req.v_coord[23])
        begin
            vq = '0;
        end
        else if (req.v_coord[22:0] > 23'(pbs_pkg::ONE_Q16))
        begin
            vq = pbs_pkg::ONE_Q16;
        end
        else
        begin
            vq = req.v_coord[16:0];
        end
    end

    assign col_ext = 32'(req.texel_col);
    assign row_ext = 32'(req.texel_row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && req_valid)
        begin
            wr1_reg      <= (req.cmd == pbs_pkg::CMD_WRITE);
            inrange1_reg <= (col_ext < 32'(MAX_WIDTH)) && (row_ext < 32'(MAX_HEIGHT));
            waddr1_reg   <= {row_ext[RW-1:0], col_ext[CW-1:0]};
            wdata1_reg.red   <= req.red_in;
            wdata1_reg.green <= req.green_in;
            wdata1_reg.blue  <= req.blue_in;
            wdata1_reg.alpha <= req.alpha_in;
            px1_reg <= PXW'(PXW'(uq) * PXW'(width)) + PXW'(pbs_pkg::HALF_Q16);
            py1_reg <= PYW'(PYW'(vq) * PYW'(height)) + PYW'(pbs_pkg::HALF_Q16);
        end
    end

    assign kx = px1_reg[PXW-1:16];
    assign ky = py1_reg[PYW-1:16];

    always_comb
    begin
        if (kx == '0)
        begin
            col0 = sph ? width - WW'(1) : '0;
        end
        else
        begin
            col0 = kx - WW'(1);
        end

        if (kx == width)
        begin
            col1 = sph ? '0 : width - WW'(1);
        end
        else
        begin
            col1 = kx;
        end

        if (ky == '0)
        begin
            row0 = !sph ? height - HH'(1) : '0;
        end
        else
        begin
            row0 = ky - HH'(1);
        end

        if (ky == height)
        begin
            row1 = !sph ? '0 : height - HH'(1);
        end
        else
        begin
            row1 = ky;
        end
    end

    assign raddr[0] = {row0[RW-1:0], col0[CW-1:0]};
    assign raddr[1] = {row0[RW-1:0], col1[CW-1:0]};
    assign raddr[2] = {row1[RW-1:0], col0[CW-1:0]};
    assign raddr[3] = {row1[RW-1:0], col1[CW-1:0]};

    assign we    = vld1_reg && wr1_reg && inrange1_reg;
    assign waddr = waddr1_reg;
    assign wdata = wdata1_reg;

    assign frac.vld = vld1_reg && !wr1_reg;
    assign frac.fx  = px1_reg[15:0];
    assign frac.fy  = py1_reg[15:0];

endmodule

### hw/rtl/pbs_blend.sv
// ----------------------------------------------------------------------------
// pbs_blend
// Bilinear weights, alpha premultiply, weighted products and the rounded
// channel sums ahead of normalisation.
// ----------------------------------------------------------------------------
module pbs_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  pbs_pkg::frac_t                    frac,
    input  pbs_pkg::texel_t                   rdata [4],
    output logic                              acc_vld,
    output logic [pbs_pkg::T_W-1:0]           acc [4]
);

    localparam int ACC_W = pbs_pkg::ACC_W;
    localparam int SUM_W = pbs_pkg::SUM_W;
    localparam int WT_W  = pbs_pkg::WT_W;
    localparam int PM_W  = pbs_pkg::PM_W;
    localparam int T_W   = pbs_pkg::T_W;

    logic             v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [15:0]      fx2_reg;
    logic [15:0]      fy2_reg;
    logic [WT_W-1:0]  wt3_reg [4];
    logic [PM_W-1:0]  pm3_reg [4][4];
    logic [ACC_W-1:0] prod4_reg [4][4];
    logic [SUM_W-1:0] lo5_reg [4];
    logic [SUM_W-1:0] hi5_reg [4];
    logic [T_W-1:0]   t6_reg [4];

    logic [16:0]      wx [4];
    logic [16:0]      wy [4];
    logic [SUM_W-1:0] total [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= frac.vld;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            wx[j] = (j % 2 == 1) ? {1'b0, fx2_reg} : pbs_pkg::ONE_Q16 - 17'(fx2_reg);
            wy[j] = (j / 2 == 1) ? {1'b0, fy2_reg} : pbs_pkg::ONE_Q16 - 17'(fy2_reg);
        end
        for (int c = 0; c < 4; c++)
        begin
            total[c] = lo5_reg[c] + hi5_reg[c] + SUM_W'(pbs_pkg::NORM_BIAS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx2_reg <= frac.fx;
            fy2_reg <= frac.fy;
            for (int j = 0; j < 4; j++)
            begin
                wt3_reg[j]    <= WT_W'(34'(wx[j]) * 34'(wy[j]));
                pm3_reg[j][0] <= PM_W'(PM_W'(rdata[j].red)   * PM_W'(rdata[j].alpha));
                pm3_reg[j][1] <= PM_W'(PM_W'(rdata[j].green) * PM_W'(rdata[j].alpha));
                pm3_reg[j][2] <= PM_W'(PM_W'(rdata[j].blue)  * PM_W'(rdata[j].alpha));
                pm3_reg[j][3] <= PM_W'(pbs_pkg::ALPHA_FULL   * PM_W'(rdata[j].alpha));
                for (int c = 0; c < 4; c++)
                begin
                    prod4_reg[j][c] <= ACC_W'(ACC_W'(pm3_reg[j][c]) * ACC_W'(wt3_reg[j]));
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                lo5_reg[c] <= SUM_W'(prod4_reg[0][c]) + SUM_W'(prod4_reg[1][c]);
                hi5_reg[c] <= SUM_W'(prod4_reg[2][c]) + SUM_W'(prod4_reg[3][c]);
                t6_reg[c]  <= T_W'(total[c] >> pbs_pkg::NORM_SHIFT);
            end
        end
    end

    assign acc_vld = v6_reg;
    assign acc     = t6_reg;

endmodule

### hw/rtl/pbs_norm.sv
// ----------------------------------------------------------------------------
// pbs_norm
// Divide each channel sum by 65025 through a reciprocal multiply with one
// correction step, saturate to Q1.15 and hold the response register.
// ----------------------------------------------------------------------------
module pbs_norm (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     acc_vld,
    input  logic [pbs_pkg::T_W-1:0]  acc [4],
    input  logic                     rsp_stall,
    output logic                     adv,
    output logic                     rsp_valid,
    output pbs_pkg::rsp_t            rsp
);

    localparam int T_W = pbs_pkg::T_W;

    logic           n1_vld_reg;
    logic           n2_vld_reg;
    logic           rsp_valid_reg;
    pbs_pkg::rsp_t  rsp_reg;
    pbs_pkg::rsp_t  rsp_next;
    logic [T_W-1:0] t1_reg [4];
    logic [15:0]    q1_reg [4];
    logic [T_W-1:0] t2_reg [4];
    logic [15:0]    q2_reg [4];
    logic [31:0]    m2_reg [4];

    logic [47:0]    recip [4];
    logic [31:0]    rem [4];
    logic [16:0]    quo [4];
    logic [15:0]    sat [4];
    logic           out_en;

    assign adv    = !(n2_vld_reg && rsp_valid_reg && rsp_stall);
    assign out_en = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            recip[c] = 48'(acc[c]) * 48'(pbs_pkg::NORM_RECIP);
            rem[c]   = 32'(t2_reg[c]) - m2_reg[c];
            quo[c]   = 17'(q2_reg[c]) + ((rem[c] >= 32'(pbs_pkg::NORM_DIV)) ? 17'd1 : 17'd0);
            sat[c]   = (quo[c] > pbs_pkg::FULL_Q15) ? 16'(pbs_pkg::FULL_Q15) : quo[c][15:0];
        end
        rsp_next.red_out   = sat[0];
        rsp_next.green_out = sat[1];
        rsp_next.blue_out  = sat[2];
        rsp_next.alpha_out = sat[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_vld_reg    <= 1'b0;
            n2_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                n1_vld_reg <= acc_vld;
                n2_vld_reg <= n1_vld_reg;
            end
            if (out_en)
            begin
                rsp_valid_reg <= n2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t1_reg[c] <= acc[c];
                q1_reg[c] <= recip[c][47:32];
                t2_reg[c] <= t1_reg[c];
                q2_reg[c] <= q1_reg[c];
                m2_reg[c] <= 32'(q1_reg[c]) * 32'(pbs_pkg::NORM_DIV);
            end
        end
        if (out_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the premultiplied bilinear sampler. Texel writes
// and sample requests stream in through the request channel in bursts; the
// response channel stalls on its own pattern, with one long hold. A
// scoreboard keeps a copy of the texel store and the mode registers and
// predicts every filtered colour, which is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import pbs_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 128;
    localparam longint UNIT = 65536;
    localparam longint HALF = 32768;
    localparam bit [63:0] NORM = 64'd65025 << 17;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE = 16;
    localparam int LIMIT = 400000;

    class filter_scoreboard;
        texel_t texels [0:MAX_W*MAX_H-1];
        logic wrap_mode = WRAP_SPHERICAL;
        logic [8:0] width_setting = 9'(WIDTH_RESET);
        logic [7:0] height_setting = 8'(HEIGHT_RESET);
        rsp_t pending_colours [$];
        int errors = 0;

        function void flaw(string msg);
            errors++;
            if (errors <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WRAP_MODE:    wrap_mode = data[0];
                REG_IMAGE_WIDTH:  width_setting = data;
                REG_IMAGE_HEIGHT: height_setting = data[7:0];
                default: ;
            endcase
        endfunction

        function longint cols_in_use();
            if (width_setting == 0)
                return 1;
            if (width_setting > MAX_W)
                return MAX_W;
            return longint'(width_setting);
        endfunction

        function longint rows_in_use();
            if (height_setting == 0)
                return 1;
            if (height_setting > MAX_H)
                return MAX_H;
            return longint'(height_setting);
        endfunction

        function longint unit_position(logic signed [23:0] raw, bit wraps);
            longint s;
            if (wraps)
                return longint'(raw[15:0]);
            s = longint'(raw);
            if (s < 0)
                return 0;
            if (s > UNIT)
                return UNIT;
            return s;
        endfunction

        function longint fold_index(longint i, longint n, bit wraps);
            if (wraps)
            begin
                if (i < 0)
                    return i + n;
                if (i >= n)
                    return i - n;
                return i;
            end
            if (i < 0)
                return 0;
            if (i > n - 1)
                return n - 1;
            return i;
        endfunction

        function void locate(input logic signed [23:0] u, input logic signed [23:0] v,
                             output int c0, output int c1, output int r0, output int r1,
                             output longint fx, output longint fy);
            bit spherical;
            longint w, h, px, py, ix, iy;
            spherical = (wrap_mode == WRAP_SPHERICAL);
            w = cols_in_use();
            h = rows_in_use();
            px = unit_position(u, spherical) * w - HALF + UNIT;
            py = unit_position(v, !spherical) * h - HALF + UNIT;
            ix = px / UNIT - 1;
            iy = py / UNIT - 1;
            fx = px % UNIT;
            fy = py % UNIT;
            c0 = int'(fold_index(ix, w, spherical));
            c1 = int'(fold_index(ix + 1, w, spherical));
            r0 = int'(fold_index(iy, h, !spherical));
            r1 = int'(fold_index(iy + 1, h, !spherical));
        endfunction

        function logic [15:0] to_q15(bit [63:0] acc);
            bit [63:0] q;
            q = (acc + NORM / 2) / NORM;
            if (q > 64'd32768)
                q = 64'd32768;
            return q[15:0];
        endfunction

        function rsp_t filter_sample(req_t item);
            int col [2];
            int row [2];
            longint fx, fy;
            bit [63:0] acc [4];
            bit [63:0] wt;
            texel_t t;
            rsp_t colour;
            locate(item.u_coord, item.v_coord, col[0], col[1], row[0], row[1], fx, fy);
            acc = '{default: 64'd0};
            for (int dy = 0; dy < 2; dy++)
            begin
                for (int dx = 0; dx < 2; dx++)
                begin
                    t = texels[row[dy] * MAX_W + col[dx]];
                    wt = 64'(dx ? fx : UNIT - fx) * 64'(dy ? fy : UNIT - fy);
                    acc[0] += 64'(t.red) * t.alpha * wt;
                    acc[1] += 64'(t.green) * t.alpha * wt;
                    acc[2] += 64'(t.blue) * t.alpha * wt;
                    acc[3] += 64'd255 * t.alpha * wt;
                end
            end
            colour.red_out = to_q15(acc[0]);
            colour.green_out = to_q15(acc[1]);
            colour.blue_out = to_q15(acc[2]);
            colour.alpha_out = to_q15(acc[3]);
            return colour;
        endfunction

        function void note_request(req_t item);
            texel_t t;
            if (item.cmd == CMD_WRITE)
            begin
                t.red = item.red_in;
                t.green = item.green_in;
                t.blue = item.blue_in;
                t.alpha = item.alpha_in;
                texels[int'(item.texel_row) * MAX_W + int'(item.texel_col)] = t;
            end
            else
            begin
                pending_colours.push_back(filter_sample(item));
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_colours.size() == 0)
            begin
                flaw($sformatf("unexpected response r=%0d g=%0d b=%0d a=%0d",
                               got.red_out, got.green_out, got.blue_out, got.alpha_out));
                return;
            end
            want = pending_colours.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out)
            begin
                flaw($sformatf(
                    "mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                    want.red_out, want.green_out, want.blue_out, want.alpha_out,
                    got.red_out, got.green_out, got.blue_out, got.alpha_out));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    filter_scoreboard sb = new;
    bit primed [0:MAX_W*MAX_H-1];
    bit steady = 1'b0;
    int burst_left = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int cycles = 0;

    premultiplied_bilinear_sampler #(
        .MAX_WIDTH(MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // hold off for a long stretch on request, otherwise stall in changing moods
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            rsp_stall <= 1'b1;
            holds_served <= holds_served + 1;
            hold_left <= 120;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(5, 60);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2: rsp_stall <= ($urandom_range(0, 3) != 0);
                default: rsp_stall <= mode_left[2];
            endcase
        end
    end

    task automatic send(input req_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!steady)
            begin
                gap = $urandom_range(1, 10);
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_colours.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic configure(input logic [8:0] mode_word, input logic [8:0] width_word,
                             input logic [8:0] height_word, input bit poke_spare);
        write_reg(REG_WRAP_MODE, mode_word);
        write_reg(REG_IMAGE_WIDTH, width_word);
        write_reg(REG_IMAGE_HEIGHT, height_word);
        if (poke_spare)
            write_reg(REG_SPARE, 9'($urandom));
        cfg_wen <= 1'b0;
    endtask

    function automatic texel_t random_texel();
        texel_t t;
        t = texel_t'($urandom);
        case ($urandom_range(0, 3))
            0: t.alpha = 8'd0;
            1: t.alpha = 8'd255;
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [23:0] pick_coord(input bit clamped);
        case ($urandom_range(0, 9))
            0, 1: return 24'($urandom);
            2: return clamped ? 24'd65536 : {8'($urandom), 16'hFFFF};
            3: return clamped ? 24'(-$urandom_range(1, 4000)) : {8'($urandom), 16'h0000};
            4: return clamped ? 24'($urandom_range(65537, 70000)) : 24'($urandom);
            default: return clamped ? 24'($urandom_range(0, 65536)) : 24'($urandom);
        endcase
    endfunction

    task automatic put_texel(input int col, input int row, input texel_t t);
        req_t item;
        item = req_t'({$urandom, $urandom, $urandom});
        item.cmd = CMD_WRITE;
        item.texel_col = 8'(col);
        item.texel_row = 7'(row);
        item.red_in = t.red;
        item.green_in = t.green;
        item.blue_in = t.blue;
        item.alpha_in = t.alpha;
        primed[row * MAX_W + col] = 1'b1;
        send(item);
    endtask

    task automatic prime(input int col, input int row);
        if (!primed[row * MAX_W + col])
            put_texel(col, row, random_texel());
    endtask

    task automatic sample(input logic [23:0] u, input logic [23:0] v);
        int c0, c1, r0, r1;
        longint fx, fy;
        req_t item;
        sb.locate(u, v, c0, c1, r0, r1, fx, fy);
        prime(c0, r0);
        prime(c1, r0);
        prime(c0, r1);
        prime(c1, r1);
        item = req_t'({$urandom, $urandom, $urandom});
        item.cmd = CMD_SAMPLE;
        item.u_coord = u;
        item.v_coord = v;
        send(item);
    endtask

    task automatic random_item();
        bit spherical;
        int col, row;
        spherical = (sb.wrap_mode == WRAP_SPHERICAL);
        if ($urandom_range(0, 9) < 3)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                col = $urandom_range(0, int'(sb.cols_in_use()) - 1);
                row = $urandom_range(0, int'(sb.rows_in_use()) - 1);
            end
            else
            begin
                col = $urandom_range(0, MAX_W - 1);
                row = $urandom_range(0, MAX_H - 1);
            end
            put_texel(col, row, random_texel());
        end
        else
        begin
            sample(pick_coord(!spherical), pick_coord(spherical));
        end
    endtask

    initial
    begin
        int p;
        wait (rst_n === 1'b1);
        @(posedge clk);

        put_texel(0, 0, texel_t'(32'hFFFF_FFFF));
        put_texel(255, 0, texel_t'(32'hFFFF_FFFF));
        sample(24'd0, 24'd0);
        put_texel(255, 127, texel_t'(32'h0));
        put_texel(0, 127, texel_t'(32'h0));
        sample(24'h00FFFF, 24'd65536);
        sample(24'h800000, 24'h7FFFFF);
        sample(24'h7FFFFF, 24'h800000);
        put_texel(128, 64, texel_t'(32'h8032_64C8));
        sample(24'h008000, 24'h008000);
        put_texel(7, 3, texel_t'(32'h0000_00FF));
        sample(24'd1920, 24'd1792);
        repeat (4) sample(24'($urandom), 24'($urandom_range(0, 65536)));

        for (p = 0; p < 8; p++)
        begin
            settle();
            case (p)
                0: configure({8'($urandom), WRAP_RING}, 9'd1, 9'd1, 1'b0);
                1: configure({8'h00, WRAP_SPHERICAL}, 9'd0, 9'd0, 1'b0);
                2: configure({8'h00, WRAP_RING}, 9'd256, 9'd128, 1'b1);
                3: configure({8'($urandom), WRAP_SPHERICAL}, 9'd511, {1'b1, 8'd255}, 1'b1);
                default: configure({8'($urandom), 1'($urandom)}, 9'($urandom_range(1, 24)),
                                   9'($urandom_range(1, 24)), 1'($urandom));
            endcase
            if (p == 2)
            begin
                steady = 1'b1;
                holds_asked++;
            end
            repeat (50) random_item();
            steady = 1'b0;
        end

        settle();
        if (sb.errors == 0 && sb.pending_colours.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
